[rtl/escaped_frame_deframer_macros.svh]
// Assertion macros used by the deframer back end.
`ifndef ESCAPED_FRAME_DEFRAMER_MACROS_SVH
`define ESCAPED_FRAME_DEFRAMER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define EFD_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define EFD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/efd_pkg.sv]
// Package with types, codes and constants of the escaped frame deframer.
package efd_pkg;

    localparam int EFD_MAX_FRAME_BYTES = 64 * 1024;
    localparam int MIN_UNESC = 7;
    localparam int HDR_BYTES = 6;
    localparam int PCOUNT_W = 17;
    localparam int CFG_IDX_W = 3;
    localparam int QDEPTH = 2;
    localparam int QPTR_W = $clog2(QDEPTH);

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_START_MARKER = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_END_MARKER = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ESCAPE_BYTE = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CODE_FOR_END = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_CODE_FOR_ESCAPE = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_CODE_FOR_START = 3'd5;

    // Verdict status codes.
    localparam logic [2:0] ST_GOOD = 3'd0;
    localparam logic [2:0] ST_BAD_ESCAPE = 3'd1;
    localparam logic [2:0] ST_TOO_SHORT = 3'd2;
    localparam logic [2:0] ST_CHECKSUM = 3'd3;
    localparam logic [2:0] ST_LENGTH = 3'd4;
    localparam logic [2:0] ST_OVERFLOW = 3'd5;

    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_VERDICT = 1'b1;

    // Operations handed from the front end to the back end.
    typedef logic [1:0] t_op_code;
    localparam t_op_code OP_FLUSH = 2'd0;
    localparam t_op_code OP_DATA = 2'd1;
    localparam t_op_code OP_END = 2'd2;
    localparam t_op_code OP_ABORT = 2'd3;

    typedef struct packed {
        t_op_code   code;
        logic [7:0] data;
        logic       bad_esc;
    } t_op;

endpackage

[rtl/efd_if.sv]
// Channel interfaces of the escaped frame deframer.
interface efd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;
    logic       flush;
    modport source (output valid, output rx_byte, output flush, input ready);
    modport sink (input valid, input rx_byte, input flush, output ready);
endinterface

interface efd_out_if;
    logic        valid;
    logic        ready;
    logic        kind;
    logic [7:0]  data_byte;
    logic [2:0]  status;
    logic [7:0]  frame_type;
    logic [7:0]  sequence_res;
    logic [16:0] payload_count;
    modport source (output valid, output kind, output data_byte, output status,
                    output frame_type, output sequence_res, output payload_count,
                    input ready);
    modport sink (input valid, input kind, input data_byte, input status,
                  input frame_type, input sequence_res, input payload_count,
                  output ready);
endinterface

interface efd_cfg_if;
    logic       valid;
    logic       ready;
    logic [2:0] index;
    logic [7:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

[rtl/efd_front.sv]
// Front end: configuration registers, frame hunting, escape decoding and overflow check.
module efd_front
    import efd_pkg::*;
#(
    parameter int MAX_FRAME_BYTES = EFD_MAX_FRAME_BYTES
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    efd_in_if.sink        i_in,
    efd_cfg_if.sink       i_cfg,
    input  logic          i_q_full,
    output logic          o_push,
    output t_op           o_op
);

    localparam int RAW_W = $clog2(MAX_FRAME_BYTES);
    localparam logic [RAW_W-1:0] RAW_LAST = RAW_W'(MAX_FRAME_BYTES - 1);

    logic [7:0] r_start, r_end, r_esc, r_c_end, r_c_esc, r_c_start;
    logic       r_in_frame, n_in_frame;
    logic       r_esc_pend, n_esc_pend;
    logic       r_esc_err, n_esc_err;
    logic [RAW_W-1:0] r_raw, n_raw;
    logic       accept;

    assign i_cfg.ready = 1'b1;
    assign i_in.ready = !i_q_full;
    assign accept = i_in.valid && !i_q_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start   <= 8'd62;
            r_end     <= 8'd60;
            r_esc     <= 8'd61;
            r_c_end   <= 8'd44;
            r_c_esc   <= 8'd45;
            r_c_start <= 8'd46;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                CFG_START_MARKER:    r_start <= i_cfg.data;
                CFG_END_MARKER:      r_end <= i_cfg.data;
                CFG_ESCAPE_BYTE:     r_esc <= i_cfg.data;
                CFG_CODE_FOR_END:    r_c_end <= i_cfg.data;
                CFG_CODE_FOR_ESCAPE: r_c_esc <= i_cfg.data;
                CFG_CODE_FOR_START:  r_c_start <= i_cfg.data;
                default: ;
            endcase
        end
    end

    always_comb begin
        n_in_frame = r_in_frame;
        n_esc_pend = r_esc_pend;
        n_esc_err  = r_esc_err;
        n_raw      = r_raw;
        o_push     = 1'b0;
        o_op.code  = OP_DATA;
        o_op.data  = i_in.rx_byte;
        o_op.bad_esc = r_esc_err || r_esc_pend;
        if (accept) begin
            if (i_in.flush) begin
                n_in_frame = 1'b0;
                n_esc_pend = 1'b0;
                n_esc_err  = 1'b0;
                n_raw      = '0;
                o_push     = 1'b1;
                o_op.code  = OP_FLUSH;
            end else if (!r_in_frame) begin
                if (i_in.rx_byte == r_start) begin
                    n_in_frame = 1'b1;
                    n_esc_pend = 1'b0;
                    n_esc_err  = 1'b0;
                    n_raw      = RAW_W'(1);
                end
            end else if (i_in.rx_byte == r_end) begin
                n_in_frame = 1'b0;
                n_esc_pend = 1'b0;
                n_esc_err  = 1'b0;
                n_raw      = '0;
                o_push     = 1'b1;
                o_op.code  = OP_END;
            end else if (r_raw >= RAW_LAST) begin
                // No room left for the end marker: abort the frame.
                n_in_frame = 1'b0;
                n_esc_pend = 1'b0;
                n_esc_err  = 1'b0;
                n_raw      = '0;
                o_push     = 1'b1;
                o_op.code  = OP_ABORT;
            end else begin
                n_raw = r_raw + RAW_W'(1);
                if (r_esc_err) begin
                    o_push = 1'b0;
                end else if (r_esc_pend) begin
                    n_esc_pend = 1'b0;
                    if (i_in.rx_byte == r_c_end) begin
                        o_push    = 1'b1;
                        o_op.data = r_end;
                    end else if (i_in.rx_byte == r_c_esc) begin
                        o_push    = 1'b1;
                        o_op.data = r_esc;
                    end else if (i_in.rx_byte == r_c_start) begin
                        o_push    = 1'b1;
                        o_op.data = r_start;
                    end else begin
                        n_esc_err = 1'b1;
                    end
                end else if (i_in.rx_byte == r_esc) begin
                    n_esc_pend = 1'b1;
                end else begin
                    o_push = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_frame <= 1'b0;
            r_esc_pend <= 1'b0;
            r_esc_err  <= 1'b0;
            r_raw      <= '0;
        end else begin
            r_in_frame <= n_in_frame;
            r_esc_pend <= n_esc_pend;
            r_esc_err  <= n_esc_err;
            r_raw      <= n_raw;
        end
    end

endmodule

[rtl/efd_queue.sv]
// Two-entry operation queue between the front end and the back end.
module efd_queue
    import efd_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_op  i_op,
    input  logic i_pop,
    output logic o_full,
    output logic o_valid,
    output t_op  o_op
);

    t_op               r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QPTR_W:0]   r_count;
    logic              do_pop;

    assign o_full  = (r_count == (QPTR_W+1)'(QDEPTH));
    assign o_valid = (r_count != '0);
    assign o_op    = r_mem[r_rd_ptr];
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (i_push && !o_full) begin
            r_mem[r_wr_ptr] <= i_op;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push && !o_full) begin
                r_wr_ptr <= r_wr_ptr + QPTR_W'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + QPTR_W'(1);
            end
            if ((i_push && !o_full) && !do_pop) begin
                r_count <= r_count + (QPTR_W+1)'(1);
            end else if (!(i_push && !o_full) && do_pop) begin
                r_count <= r_count - (QPTR_W+1)'(1);
            end
        end
    end

endmodule

[rtl/efd_back.sv]
// Back end: header capture, checksum, held payload byte, verdict and output register.
module efd_back
    import efd_pkg::*;
#(
    parameter int MAX_FRAME_BYTES = EFD_MAX_FRAME_BYTES
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_q_valid,
    input  t_op       i_op,
    output logic      o_pop,
    efd_out_if.source o_out
);

    `include "escaped_frame_deframer_macros.svh"

    localparam int CNT_W = $clog2(MAX_FRAME_BYTES + 1);
    localparam logic [CNT_W-1:0] CNT_MIN = CNT_W'(MIN_UNESC);
    localparam logic [CNT_W-1:0] CNT_HDR = CNT_W'(HDR_BYTES);

    logic [CNT_W-1:0] r_unesc, n_unesc;
    logic [7:0]       r_sum, n_sum;
    logic [7:0]       r_held, n_held;
    logic             r_held_valid, n_held_valid;
    logic [7:0]       r_type, n_type;
    logic [7:0]       r_seq, n_seq;
    logic [31:0]      r_len, n_len;

    logic             r_out_valid, n_out_valid;
    logic             r_kind, n_kind;
    logic [7:0]       r_data, n_data;
    logic [2:0]       r_status, n_status;
    logic [7:0]       r_ftype, n_ftype;
    logic [7:0]       r_fseq, n_fseq;
    logic [PCOUNT_W-1:0] r_pcount, n_pcount;

    logic [2:0]       verdict;
    logic [CNT_W-1:0] forwarded;
    logic             out_load;

    assign o_pop = i_q_valid && (!r_out_valid || o_out.ready);
    assign forwarded = (r_unesc >= CNT_MIN) ? (r_unesc - CNT_MIN) : '0;

    // Checks run in priority order: escape, length floor, checksum, declared length.
    always_comb begin
        if (i_op.bad_esc) begin
            verdict = ST_BAD_ESCAPE;
        end else if (r_unesc < CNT_MIN) begin
            verdict = ST_TOO_SHORT;
        end else if (!r_held_valid || (r_sum != r_held)) begin
            verdict = ST_CHECKSUM;
        end else if (32'(forwarded) != r_len) begin
            verdict = ST_LENGTH;
        end else begin
            verdict = ST_GOOD;
        end
    end

    always_comb begin
        n_unesc      = r_unesc;
        n_sum        = r_sum;
        n_held       = r_held;
        n_held_valid = r_held_valid;
        n_type       = r_type;
        n_seq        = r_seq;
        n_len        = r_len;
        n_kind       = r_kind;
        n_data       = r_data;
        n_status     = r_status;
        n_ftype      = r_ftype;
        n_fseq       = r_fseq;
        n_pcount     = r_pcount;
        out_load     = 1'b0;
        if (o_pop) begin
            case (i_op.code)
                OP_FLUSH: begin
                    n_unesc      = '0;
                    n_sum        = '0;
                    n_held       = '0;
                    n_held_valid = 1'b0;
                    n_type       = '0;
                    n_seq        = '0;
                    n_len        = '0;
                end
                OP_DATA: begin
                    if (r_unesc < CNT_HDR) begin
                        if (r_unesc == CNT_W'(0)) begin
                            n_type = i_op.data;
                        end else if (r_unesc == CNT_W'(1)) begin
                            n_seq = i_op.data;
                        end else begin
                            n_len = {r_len[23:0], i_op.data};
                        end
                        n_sum = r_sum + i_op.data;
                    end else begin
                        // The previous byte is now known not to be the checksum.
                        if (r_held_valid) begin
                            n_sum    = r_sum + r_held;
                            out_load = 1'b1;
                            n_kind   = KIND_PAYLOAD;
                            n_data   = r_held;
                            n_status = ST_GOOD;
                            n_ftype  = '0;
                            n_fseq   = '0;
                            n_pcount = '0;
                        end
                        n_held       = i_op.data;
                        n_held_valid = 1'b1;
                    end
                    n_unesc = r_unesc + CNT_W'(1);
                end
                OP_END, OP_ABORT: begin
                    out_load     = 1'b1;
                    n_kind       = KIND_VERDICT;
                    n_data       = '0;
                    n_status     = (i_op.code == OP_ABORT) ? ST_OVERFLOW : verdict;
                    n_ftype      = r_type;
                    n_fseq       = r_seq;
                    n_pcount     = PCOUNT_W'(forwarded);
                    n_unesc      = '0;
                    n_sum        = '0;
                    n_held       = '0;
                    n_held_valid = 1'b0;
                    n_type       = '0;
                    n_seq        = '0;
                    n_len        = '0;
                end
                default: ;
            endcase
        end
        if (o_pop) begin
            n_out_valid = out_load;
        end else begin
            n_out_valid = r_out_valid && !o_out.ready;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_unesc      <= '0;
            r_sum        <= '0;
            r_held       <= '0;
            r_held_valid <= 1'b0;
            r_type       <= '0;
            r_seq        <= '0;
            r_len        <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_unesc      <= n_unesc;
            r_sum        <= n_sum;
            r_held       <= n_held;
            r_held_valid <= n_held_valid;
            r_type       <= n_type;
            r_seq        <= n_seq;
            r_len        <= n_len;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind   <= n_kind;
        r_data   <= n_data;
        r_status <= n_status;
        r_ftype  <= n_ftype;
        r_fseq   <= n_fseq;
        r_pcount <= n_pcount;
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.kind          = r_kind;
    assign o_out.data_byte     = r_data;
    assign o_out.status        = r_status;
    assign o_out.frame_type    = r_ftype;
    assign o_out.sequence_res  = r_fseq;
    assign o_out.payload_count = r_pcount;

    `EFD_ASSERT_NEXT(a_verdict_clears, i_clk, i_rst_n,
        o_pop && (i_op.code == OP_END || i_op.code == OP_ABORT),
        r_unesc == '0 && !r_held_valid && r_out_valid && r_kind == KIND_VERDICT,
        "verdict did not clear the frame state")
    `EFD_ASSERT_NOW(a_held_after_header, i_clk, i_rst_n,
        r_unesc >= CNT_MIN, r_held_valid,
        "past the header but no payload byte is held")
    `EFD_ASSERT_NEXT(a_payload_forwarded, i_clk, i_rst_n,
        o_pop && i_op.code == OP_DATA && r_held_valid,
        r_out_valid && r_kind == KIND_PAYLOAD,
        "held payload byte was not forwarded")

endmodule

[rtl/escaped_frame_deframer.sv]
// Top level of the escaped frame deframer: front end, operation queue and back end.
// Usage:
// i_in carries one raw link byte per request (rx_byte) and a flush flag that drops any
// partial frame. o_out carries one result per request: a tentative payload byte
// (kind 0) or an end-of-frame verdict (kind 1) with status, frame type, sequence
// and the count of payload bytes forwarded; keep the payload only on a good verdict.
// i_cfg writes the six marker and escape code registers by index; it is always ready
// and should be used only while no frame traffic is in flight.
// Throughput is one input byte per cycle while the queue is not full. A result reaches
// o_out through the queue and the output register: the front end classifies the byte
// as it is accepted and writes the queue, and the back end loads the output register
// when it pops that entry.
// Each payload byte is released when the next unescaped byte arrives, since the
// last byte before the end marker is the checksum.
// If the receiver stalls, the output register holds its result and the two-entry
// queue fills; i_in.ready drops once the queue is full.
// Synchronous reset restores the default markers, clears all frame state and the
// queue, and leaves the block hunting for a start marker.
module escaped_frame_deframer
    import efd_pkg::*;
#(
    parameter int MAX_FRAME_BYTES = EFD_MAX_FRAME_BYTES
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    efd_in_if.sink    i_in,
    efd_cfg_if.sink   i_cfg,
    efd_out_if.source o_out
);

    logic q_full;
    logic push;
    t_op  push_op;
    logic q_valid;
    t_op  head_op;
    logic pop;

    efd_front #(
        .MAX_FRAME_BYTES(MAX_FRAME_BYTES)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in     (i_in),
        .i_cfg    (i_cfg),
        .i_q_full (q_full),
        .o_push   (push),
        .o_op     (push_op)
    );

    efd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_op    (push_op),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_op    (head_op)
    );

    efd_back #(
        .MAX_FRAME_BYTES(MAX_FRAME_BYTES)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_op      (head_op),
        .o_pop     (pop),
        .o_out     (o_out)
    );

endmodule

[sim/testbench.sv]
// Self-checking testbench of the escaped frame deframer with a built-in byte-level predictor.
`timescale 1ns / 100ps

module testbench;
    import efd_pkg::*;

    typedef struct packed {
        logic        kind;
        logic [7:0]  data_byte;
        logic [2:0]  status;
        logic [7:0]  frame_type;
        logic [7:0]  sequence_res;
        logic [16:0] payload_count;
    } t_deframer_result;

    typedef enum int {
        FRAME_GOOD,
        FRAME_BAD_SUM,
        FRAME_BAD_LEN,
        FRAME_SHORT,
        FRAME_BAD_CODE,
        FRAME_ESC_AT_END,
        FRAME_FLUSHED
    } t_frame_fault;

    logic i_clk;
    logic i_rst_n;

    efd_in_if  in_ch ();
    efd_cfg_if cfg_ch ();
    efd_out_if out_ch ();

    escaped_frame_deframer DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .i_cfg   (cfg_ch),
        .o_out   (out_ch)
    );

    // Marker settings and frame state as the predictor sees them.
    logic [7:0]  start_mark, end_mark, esc_mark;
    logic [7:0]  end_code, esc_code, start_code;
    bit          in_frame, esc_pending, esc_bad, held_ok;
    int          unesc_cnt, raw_cnt;
    logic [7:0]  run_sum, held_byte, hdr_type, hdr_seq;
    logic [31:0] hdr_len;

    t_deframer_result frame_out_q[$];
    logic [7:0]       link_bytes[$];
    logic [7:0]       frame_payload[$];

    int  mismatch_count = 0;
    int  frame_items = 0;
    int  gap_pct = 0;
    int  stall_pct = 0;
    int  start_escape_pct = 50;
    bit  idle_on = 1'b1;

    initial i_clk = 1'b0;
    always #4 i_clk = ~i_clk;

    initial begin
        #(200_000_000);
        $display("Regression FAIL");
        $finish;
    end

    // Receiver side: ready drops for random bursts while stall_pct is nonzero.
    always begin
        @(negedge i_clk);
        if (stall_pct != 0 && $urandom_range(99) < stall_pct) begin
            out_ch.ready <= 1'b0;
            repeat ($urandom_range(18, 1)) @(negedge i_clk);
        end
        out_ch.ready <= 1'b1;
    end

    function automatic string fmt_result(input t_deframer_result r);
        return $sformatf("kind %0d data %02h status %0d type %02h seq %02h count %0d",
                         r.kind, r.data_byte, r.status, r.frame_type, r.sequence_res,
                         r.payload_count);
    endfunction

    always @(posedge i_clk) begin : check_results
        t_deframer_result got, want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            got.kind = out_ch.kind;
            got.data_byte = out_ch.data_byte;
            got.status = out_ch.status;
            got.frame_type = out_ch.frame_type;
            got.sequence_res = out_ch.sequence_res;
            got.payload_count = out_ch.payload_count;
            if (frame_out_q.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("%0t: result with nothing pending: %s", $time, fmt_result(got));
            end else begin
                want = frame_out_q.pop_front();
                if (got.kind !== want.kind || got.data_byte !== want.data_byte ||
                        got.status !== want.status || got.frame_type !== want.frame_type ||
                        got.sequence_res !== want.sequence_res ||
                        got.payload_count !== want.payload_count) begin
                    mismatch_count++;
                    if (mismatch_count <= 10) begin
                        $display("%0t: mismatch", $time);
                        $display("    expected %s", fmt_result(want));
                        $display("    actual   %s", fmt_result(got));
                    end
                end
            end
        end
    end

    // ---------------- predictor ----------------

    task automatic drop_frame();
        in_frame = 1'b0;
        esc_pending = 1'b0;
        esc_bad = 1'b0;
        held_ok = 1'b0;
        unesc_cnt = 0;
        raw_cnt = 0;
        hdr_len = '0;
        run_sum = '0;
        held_byte = '0;
        hdr_type = '0;
        hdr_seq = '0;
    endtask

    task automatic push_verdict(input logic [2:0] st);
        t_deframer_result r;
        r.kind = KIND_VERDICT;
        r.data_byte = 8'h00;
        r.status = st;
        r.frame_type = hdr_type;
        r.sequence_res = hdr_seq;
        r.payload_count = (unesc_cnt >= MIN_UNESC) ? 17'(unesc_cnt - MIN_UNESC) : 17'd0;
        frame_out_q = {frame_out_q, r};
        drop_frame();
    endtask

    // One decoded byte: header bytes are captured, later ones are released one byte late.
    task automatic take_unescaped(input logic [7:0] b);
        t_deframer_result r;
        if (unesc_cnt < HDR_BYTES) begin
            if (unesc_cnt == 0)
                hdr_type = b;
            else if (unesc_cnt == 1)
                hdr_seq = b;
            else
                hdr_len = {hdr_len[23:0], b};
            run_sum += b;
        end else begin
            if (held_ok) begin
                run_sum += held_byte;
                r = '0;
                r.kind = KIND_PAYLOAD;
                r.data_byte = held_byte;
                frame_out_q = {frame_out_q, r};
            end
            held_byte = b;
            held_ok = 1'b1;
        end
        if (unesc_cnt < 17'h1FFFF) unesc_cnt++;
    endtask

    task automatic deframe_byte(input logic [7:0] b, input logic fl);
        if (fl) begin
            drop_frame();
            return;
        end
        if (!in_frame) begin
            if (b == start_mark) begin
                drop_frame();
                in_frame = 1'b1;
                raw_cnt = 1;
            end
            return;
        end
        // The end marker closes the frame before any escape decoding.
        if (b == end_mark) begin
            if (esc_bad || esc_pending)
                push_verdict(ST_BAD_ESCAPE);
            else if (unesc_cnt < MIN_UNESC)
                push_verdict(ST_TOO_SHORT);
            else if (!held_ok || run_sum != held_byte)
                push_verdict(ST_CHECKSUM);
            else if (32'(unesc_cnt - MIN_UNESC) != hdr_len)
                push_verdict(ST_LENGTH);
            else
                push_verdict(ST_GOOD);
            return;
        end
        if (raw_cnt + 1 >= EFD_MAX_FRAME_BYTES) begin
            push_verdict(ST_OVERFLOW);
            return;
        end
        raw_cnt++;
        if (esc_bad) return;
        if (esc_pending) begin
            esc_pending = 1'b0;
            if (b == end_code)
                take_unescaped(end_mark);
            else if (b == esc_code)
                take_unescaped(esc_mark);
            else if (b == start_code)
                take_unescaped(start_mark);
            else
                esc_bad = 1'b1;
            return;
        end
        if (b == esc_mark) begin
            esc_pending = 1'b1;
            return;
        end
        take_unescaped(b);
    endtask

    // ---------------- channel drivers ----------------

    // Called at a falling edge; returns at the falling edge after the request is taken.
    task automatic push_byte(input logic [7:0] b, input logic fl);
        bit was_in;
        if (gap_pct != 0 && $urandom_range(99) < gap_pct) begin
            in_ch.valid <= 1'b0;
            in_ch.rx_byte <= 8'($urandom_range(255));
            repeat ($urandom_range(18, 1)) @(negedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.rx_byte <= b;
        in_ch.flush <= fl;
        do @(posedge i_clk); while (!in_ch.ready);
        was_in = in_frame;
        deframe_byte(b, fl);
        if (was_in || fl || in_frame) frame_items++;
        @(negedge i_clk);
    endtask

    task automatic send_link_bytes();
        foreach (link_bytes[i]) push_byte(link_bytes[i], 1'b0);
        link_bytes.delete();
    endtask

    task automatic wait_results_drained();
        int guard;
        in_ch.valid <= 1'b0;
        guard = 0;
        while (frame_out_q.size() != 0 && guard < 200000) begin
            @(negedge i_clk);
            guard++;
        end
        // Bytes that cause no result may still be in the pipeline.
        repeat (6) @(negedge i_clk);
    endtask

    task automatic load_markers(input logic [7:0] vals[6]);
        logic [CFG_IDX_W-1:0] reg_order[6];
        reg_order = '{CFG_START_MARKER, CFG_END_MARKER, CFG_ESCAPE_BYTE,
                      CFG_CODE_FOR_END, CFG_CODE_FOR_ESCAPE, CFG_CODE_FOR_START};
        wait_results_drained();
        for (int i = 0; i < 6; i++) begin
            cfg_ch.valid <= 1'b1;
            cfg_ch.index <= reg_order[i];
            cfg_ch.data <= vals[i];
            do @(posedge i_clk); while (!cfg_ch.ready);
            case (reg_order[i])
                CFG_START_MARKER:    start_mark = vals[i];
                CFG_END_MARKER:      end_mark = vals[i];
                CFG_ESCAPE_BYTE:     esc_mark = vals[i];
                CFG_CODE_FOR_END:    end_code = vals[i];
                CFG_CODE_FOR_ESCAPE: esc_code = vals[i];
                CFG_CODE_FOR_START:  start_code = vals[i];
                default: ;
            endcase
            @(negedge i_clk);
        end
        cfg_ch.valid <= 1'b0;
    endtask

    // ---------------- frame construction ----------------

    function automatic logic [7:0] any_link_byte();
        case ($urandom_range(7))
            0: return start_mark;
            1: return end_mark;
            2: return esc_mark;
            3: return end_code;
            4: return esc_code;
            5: return start_code;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    // Appends one decoded byte to the link, escaped where it has to be (or may be).
    function automatic void encode_into(input logic [7:0] u);
        logic [7:0] codes[3];
        logic [7:0] dec;
        bit         must;
        codes = '{end_code, esc_code, start_code};
        must = (u == end_mark) || (u == esc_mark) ||
               (u == start_mark && $urandom_range(99) < start_escape_pct);
        if (must) begin
            foreach (codes[k]) begin
                dec = (codes[k] == end_code) ? end_mark :
                      (codes[k] == esc_code) ? esc_mark : start_mark;
                if (codes[k] != end_mark && dec == u) begin
                    link_bytes = {link_bytes, esc_mark};
                    link_bytes = {link_bytes, codes[k]};
                    return;
                end
            end
        end
        link_bytes = {link_bytes, u};
    endfunction

    task automatic fill_payload(input int n);
        frame_payload.delete();
        repeat (n) begin
            if ($urandom_range(3) == 0)
                frame_payload = {frame_payload, any_link_byte()};
            else
                frame_payload = {frame_payload, 8'($urandom_range(255))};
        end
    endtask

    task automatic send_frame(input t_frame_fault fault, input logic [7:0] typ, sq,
                              input logic [31:0] len_flip);
        logic [7:0]  body[$];
        logic [7:0]  bad_code;
        logic [7:0]  csum;
        logic [31:0] len_field;
        int          keep, pos;
        len_field = frame_payload.size();
        if (fault == FRAME_BAD_LEN) len_field ^= len_flip;
        body = '{typ, sq, len_field[31:24], len_field[23:16], len_field[15:8], len_field[7:0]};
        foreach (frame_payload[i]) body = {body, frame_payload[i]};
        csum = 8'h00;
        foreach (body[i]) csum += body[i];
        if (fault == FRAME_BAD_SUM) csum += 8'($urandom_range(255, 1));
        body = {body, csum};
        if (fault == FRAME_SHORT) begin
            keep = $urandom_range(6);
            while (body.size() > keep) void'(body.pop_back());
        end
        link_bytes.delete();
        link_bytes = {link_bytes, start_mark};
        foreach (body[i]) encode_into(body[i]);
        if (fault == FRAME_BAD_CODE) begin
            do bad_code = 8'($urandom_range(255));
            while (bad_code == end_code || bad_code == esc_code || bad_code == start_code ||
                   bad_code == end_mark);
            pos = $urandom_range(link_bytes.size(), 1);
            link_bytes.insert(pos, bad_code);
            link_bytes.insert(pos, esc_mark);
        end
        if (fault == FRAME_ESC_AT_END) link_bytes = {link_bytes, esc_mark};
        if (fault == FRAME_FLUSHED) begin
            keep = $urandom_range(link_bytes.size(), 1);
            while (link_bytes.size() > keep) void'(link_bytes.pop_back());
            send_link_bytes();
            push_byte(8'($urandom_range(255)), 1'b1);
        end else begin
            link_bytes = {link_bytes, end_mark};
            send_link_bytes();
        end
    endtask

    function automatic logic [7:0] header_byte();
        case ($urandom_range(9))
            0: return 8'h00;
            1: return 8'hFF;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    task automatic send_random_frame();
        t_frame_fault fault;
        int           roll;
        logic [7:0]   nb;
        if (idle_on) begin
            case ($urandom_range(2))
                0: gap_pct = 0;
                1: gap_pct = 4;
                default: gap_pct = 20;
            endcase
            case ($urandom_range(2))
                0: stall_pct = 0;
                1: stall_pct = 4;
                default: stall_pct = 20;
            endcase
        end
        // Line noise between frames, mostly not the start marker.
        repeat ($urandom_range(2)) begin
            nb = 8'($urandom_range(255));
            if (nb == start_mark && $urandom_range(3) != 0) nb = nb + 8'd1;
            push_byte(nb, $urandom_range(15) == 0);
        end
        roll = $urandom_range(99);
        if (roll < 8) begin
            link_bytes.delete();
            link_bytes = {link_bytes, start_mark};
            repeat ($urandom_range(20, 1)) link_bytes = {link_bytes, any_link_byte()};
            link_bytes = {link_bytes, end_mark};
            send_link_bytes();
            return;
        end
        if (roll < 55)       fault = FRAME_GOOD;
        else if (roll < 63)  fault = FRAME_BAD_SUM;
        else if (roll < 71)  fault = FRAME_BAD_LEN;
        else if (roll < 78)  fault = FRAME_SHORT;
        else if (roll < 85)  fault = FRAME_BAD_CODE;
        else if (roll < 92)  fault = FRAME_ESC_AT_END;
        else                 fault = FRAME_FLUSHED;
        fill_payload(($urandom_range(9) == 0) ? $urandom_range(80, 17) : $urandom_range(16));
        send_frame(fault, header_byte(), header_byte(), $urandom() | 32'h1);
    endtask

    task automatic run_random_frames(input int n_items);
        int first;
        first = frame_items;
        while (frame_items - first < n_items) begin
            // Now and then hold the sender until everything pending has come out.
            if ($urandom_range(24) == 0) wait_results_drained();
            send_random_frame();
        end
    endtask

    task automatic load_random_markers();
        logic [7:0] v[6];
        v[0] = 8'($urandom_range(255));
        do v[1] = 8'($urandom_range(255)); while (v[1] == v[0]);
        do v[2] = 8'($urandom_range(255)); while (v[2] == v[0] || v[2] == v[1]);
        do v[3] = 8'($urandom_range(255)); while (v[3] == v[1]);
        do v[4] = 8'($urandom_range(255)); while (v[4] == v[1] || v[4] == v[3]);
        do v[5] = 8'($urandom_range(255));
        while (v[5] == v[1] || v[5] == v[3] || v[5] == v[4]);
        load_markers(v);
    endtask

    // ---------------- tests ----------------

    task automatic test_directed_frames();
        gap_pct = 5;
        stall_pct = 5;
        // Bytes while hunting are dropped, the end marker included.
        push_byte(8'h00, 1'b0);
        push_byte(8'hFF, 1'b0);
        push_byte(end_mark, 1'b0);
        push_byte(8'hA5, 1'b1);
        // Start followed directly by end.
        link_bytes = '{start_mark, end_mark};
        send_link_bytes();
        // Every marker value escaped inside the payload.
        start_escape_pct = 100;
        frame_payload = '{end_mark, esc_mark, start_mark, 8'h00, 8'hFF};
        send_frame(FRAME_GOOD, 8'hFF, 8'h00, 32'h0);
        // A literal start marker inside a frame is ordinary data.
        start_escape_pct = 0;
        frame_payload = '{start_mark, 8'h5A};
        send_frame(FRAME_GOOD, 8'h00, 8'hFF, 32'h0);
        start_escape_pct = 50;
        frame_payload.delete();
        send_frame(FRAME_GOOD, 8'h12, 8'h34, 32'h0);
        fill_payload(4);
        send_frame(FRAME_BAD_SUM, 8'h01, 8'h02, 32'h0);
        fill_payload(3);
        send_frame(FRAME_BAD_LEN, 8'h03, 8'h04, 32'hFFFF_FFFF ^ 32'd3);
        fill_payload(2);
        send_frame(FRAME_SHORT, 8'h05, 8'h06, 32'h0);
        fill_payload(5);
        send_frame(FRAME_BAD_CODE, 8'h07, 8'h08, 32'h0);
        fill_payload(2);
        send_frame(FRAME_ESC_AT_END, 8'h09, 8'h0A, 32'h0);
        fill_payload(6);
        send_frame(FRAME_FLUSHED, 8'h0B, 8'h0C, 32'h0);
        wait_results_drained();
    endtask

    task automatic test_marker_settings();
        run_random_frames(280);
        load_markers('{8'h00, 8'hFF, 8'h01, 8'hFE, 8'h02, 8'h80});
        run_random_frames(220);
        load_markers('{8'hFF, 8'h00, 8'hFE, 8'h01, 8'hFF, 8'h7F});
        run_random_frames(220);
        repeat (2) begin
            load_random_markers();
            run_random_frames(180);
        end
    endtask

    // Marker values that collide: end wins over escape, and the code order decides.
    task automatic test_overlapping_markers();
        load_markers('{8'h55, 8'h55, 8'h55, 8'h20, 8'h20, 8'h20});
        run_random_frames(90);
        load_markers('{8'hA0, 8'hA1, 8'hA1, 8'hA1, 8'hA0, 8'hA0});
        run_random_frames(90);
    endtask

    task automatic test_quiet_tail();
        load_markers('{8'd62, 8'd60, 8'd61, 8'd44, 8'd45, 8'd46});
        idle_on = 1'b0;
        gap_pct = 0;
        stall_pct = 0;
        run_random_frames(180);
    endtask

    initial begin
        i_rst_n = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.rx_byte = 8'h00;
        in_ch.flush = 1'b0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = CFG_START_MARKER;
        cfg_ch.data = 8'h00;
        out_ch.ready = 1'b0;
        start_mark = 8'd62;
        end_mark = 8'd60;
        esc_mark = 8'd61;
        end_code = 8'd44;
        esc_code = 8'd45;
        start_code = 8'd46;
        drop_frame();
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_directed_frames();
        test_marker_settings();
        test_overlapping_markers();
        test_quiet_tail();

        wait_results_drained();
        if (mismatch_count == 0 && frame_out_q.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

[files.f]
+incdir+rtl
rtl/efd_pkg.sv
rtl/efd_if.sv
rtl/efd_front.sv
rtl/efd_queue.sv
rtl/efd_back.sv
rtl/escaped_frame_deframer.sv
sim/testbench.sv
